@@ rtl/tsd_pkg.sv @@
`default_nettype none

package tsd_pkg;

  // Number of attached sensors and the width of a table slot index.
  localparam int SENSOR_COUNT = 8;
  localparam int SLOT_W       = $clog2(SENSOR_COUNT);

  // Change limit register.
  localparam int          LIMIT_W     = 11;
  localparam logic [10:0] LIMIT_RESET = 11'd80;

  // Resolution codes from bits 6:5 of the configuration byte.
  localparam logic [1:0] RES_9BIT  = 2'b00;
  localparam logic [1:0] RES_10BIT = 2'b01;
  localparam logic [1:0] RES_11BIT = 2'b10;
  localparam logic [1:0] RES_12BIT = 2'b11;

  // ROM code CRC: reflected polynomial, checked over the seven low bytes.
  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam int         CRC_DATA_W = 56;

  // One sensor readout request.
  typedef struct packed {
    logic [2:0]  sensor_index;
    logic [63:0] rom_code;
    logic [7:0]  temp_low_byte;
    logic [7:0]  temp_high_byte;
    logic [7:0]  resolution_byte;
    logic [31:0] time_ms;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [2:0]         out_sensor_index;
    logic               rom_valid;
    logic signed [15:0] reading;
    logic [15:0]        magnitude;
    logic               negative;
    logic               accepted;
    logic signed [15:0] filtered_temp;
  } out_rsp_t;

  // Decoded request passed from the decoder to the filter.
  typedef struct packed {
    logic [2:0]  idx;
    logic        rom_ok;
    logic [15:0] masked;
    logic [15:0] mag;
    logic        neg;
    logic [31:0] tms;
  } dec_item_t;

  // Contribution of one ROM data bit to the CRC. The CRC is linear in the
  // data, so the full CRC is the XOR of the columns of all set bits.
  function automatic logic [7:0] crc_col(input int unsigned pos);
    logic [CRC_DATA_W-1:0] data;
    logic [7:0]            crc;
    logic                  mix;
    data = '0;
    data[pos[5:0]] = 1'b1;
    crc = 8'h00;
    for (int b = 0; b < CRC_DATA_W; b++) begin
      mix = crc[0] ^ data[b];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tsd_decode.sv @@
`default_nettype none

module tsd_decode
  import tsd_pkg::*;
(
  input  var in_req_t   req,
  output dec_item_t     item
);

  logic [7:0]  crc_term [CRC_DATA_W];
  logic [7:0]  crc;
  logic [15:0] raw;
  logic [15:0] mask;
  logic [15:0] masked;

  // Per-bit CRC contributions; each column is a constant.
  for (genvar g = 0; g < CRC_DATA_W; g++) begin : g_crc
    localparam logic [7:0] COL = crc_col(g);
    assign crc_term[g] = req.rom_code[g] ? COL : 8'h00;
  end

  // XOR all contributions together.
  always_comb begin
    crc = 8'h00;
    for (int i = 0; i < CRC_DATA_W; i++) begin
      crc = crc ^ crc_term[i];
    end
  end

  // Clear the bits that are undefined at the selected resolution.
  assign raw = {req.temp_high_byte, req.temp_low_byte};

  always_comb begin
    unique case (req.resolution_byte[6:5])
      RES_9BIT:  mask = 16'hFFF8;
      RES_10BIT: mask = 16'hFFFC;
      RES_11BIT: mask = 16'hFFFE;
      RES_12BIT: mask = 16'hFFFF;
      default:   mask = 16'hFFFF;
    endcase
  end

  assign masked = raw & mask;

  // Assemble the decoded item; magnitude of 0x8000 stays 0x8000.
  assign item.idx    = req.sensor_index;
  assign item.rom_ok = (crc == req.rom_code[63:56]);
  assign item.masked = masked;
  assign item.neg    = masked[15];
  assign item.mag    = masked[15] ? 16'(~masked + 16'd1) : masked;
  assign item.tms    = req.time_ms;

endmodule

`default_nettype wire

@@ rtl/tsd_queue.sv @@
`default_nettype none

module tsd_queue
  import tsd_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst_n,
  input  var logic      wr_en,
  input  var dec_item_t wr_item,
  output logic          full,
  input  var logic      rd_en,
  output dec_item_t     rd_item,
  output logic          empty
);

  dec_item_t  slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_wr;
  logic       do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tsd_filter.sv @@
`default_nettype none

module tsd_filter
  import tsd_pkg::*;
(
  input  var logic               clk,
  input  var logic               rst_n,
  input  var logic [LIMIT_W-1:0] change_limit,
  input  var dec_item_t          item,
  input  var logic               item_valid,
  output logic                   item_take,
  output out_rsp_t               rsp,
  output logic                   rsp_empty,
  input  var logic               rsp_pop
);

  // Per-sensor state.
  logic signed [15:0] stored_temp_r    [SENSOR_COUNT];
  logic               seen_flag_r      [SENSOR_COUNT];
  logic [31:0]        last_time_r      [SENSOR_COUNT];
  logic [15:0]        last_magnitude_r [SENSOR_COUNT];
  logic               last_sign_r      [SENSOR_COUNT];

  // Result queue.
  out_rsp_t   rsp_slot_r [2];
  logic       rsp_wr_r;
  logic       rsp_rd_r;
  logic [1:0] rsp_cnt_r;
  logic [1:0] rsp_cnt_nxt;
  logic       do_pop;

  logic [SLOT_W-1:0]  slot;
  logic               in_range;
  logic signed [15:0] stored;
  logic               seen;
  logic signed [15:0] value;
  logic signed [16:0] diff;
  logic [16:0]        abs_diff;
  logic               in_limit;
  logic               acc;
  logic               upd;
  out_rsp_t           rsp_nxt;

  // A request is taken whenever the result queue has room.
  assign item_take = item_valid && (rsp_cnt_r != 2'd2);
  assign do_pop    = rsp_pop && (rsp_cnt_r != 2'd0);
  assign rsp_empty = (rsp_cnt_r == 2'd0);
  assign rsp       = rsp_slot_r[rsp_rd_r];

  // Read the addressed sensor entry.
  assign slot     = item.idx[SLOT_W-1:0];
  assign in_range = (int'(item.idx) < SENSOR_COUNT);
  assign stored   = stored_temp_r[slot];
  assign seen     = seen_flag_r[slot];
  assign value    = item.masked;

  // Signed change from the stored value, compared in 17 bits.
  assign diff     = 17'(value) - 17'(stored);
  assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
  assign in_limit = (abs_diff <= {6'd0, change_limit});
  assign acc      = item.rom_ok && in_range && (!seen || in_limit);
  assign upd      = item_take && item.rom_ok && in_range;

  // Build the result.
  always_comb begin
    rsp_nxt.out_sensor_index = item.idx;
    rsp_nxt.rom_valid        = item.rom_ok;
    rsp_nxt.reading          = item.rom_ok ? value : 16'sd0;
    rsp_nxt.magnitude        = item.rom_ok ? item.mag : 16'd0;
    rsp_nxt.negative         = item.rom_ok && item.neg;
    rsp_nxt.accepted         = acc;
    if (!in_range) begin
      rsp_nxt.filtered_temp = 16'sd0;
    end else if (acc) begin
      rsp_nxt.filtered_temp = value;
    end else begin
      rsp_nxt.filtered_temp = stored;
    end
  end

  // Stored temperature and first-reading flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        stored_temp_r[i] <= 16'sd0;
        seen_flag_r[i]   <= 1'b0;
      end
    end else if (upd && acc) begin
      stored_temp_r[slot] <= value;
      seen_flag_r[slot]   <= 1'b1;
    end
  end

  // Last readout bookkeeping, updated on every valid readout.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        last_time_r[i]      <= 32'd0;
        last_magnitude_r[i] <= 16'd0;
        last_sign_r[i]      <= 1'b0;
      end
    end else if (upd) begin
      last_time_r[slot]      <= item.tms;
      last_magnitude_r[slot] <= item.mag;
      last_sign_r[slot]      <= item.neg;
    end
  end

  // Result queue control.
  always_comb begin
    rsp_cnt_nxt = rsp_cnt_r;
    if (item_take && !do_pop) begin
      rsp_cnt_nxt = rsp_cnt_r + 2'd1;
    end else if (do_pop && !item_take) begin
      rsp_cnt_nxt = rsp_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_wr_r  <= 1'b0;
      rsp_rd_r  <= 1'b0;
      rsp_cnt_r <= 2'd0;
    end else begin
      rsp_wr_r  <= item_take ? !rsp_wr_r : rsp_wr_r;
      rsp_rd_r  <= do_pop ? !rsp_rd_r : rsp_rd_r;
      rsp_cnt_r <= rsp_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      rsp_slot_r[rsp_wr_r] <= rsp_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/temp_sensor_decode_spike_filter.sv @@
// Temperature readout decoder with a per-sensor change-limit filter.
// Requests enter as queue pushes: in_req is taken at a clock edge where push
// is high and full is low. Each request carries one scratchpad readout for
// one sensor. The decoder checks the ROM code CRC, masks the reading by its
// resolution and writes the decoded request into a two-entry queue. The filter
// pops that queue, does a read-modify-write of the sensor's
// entry and writes one result into a two-entry result queue.
// Results leave as queue pops: out_rsp is valid while empty is low and is
// taken at an edge where pop is high.
// A request taken is registered into the middle queue and its result into the
// result queue, from which it can be popped; throughput is one request per
// cycle while pop keeps up, set by the table update in the filter.
// When pop stays low the result queue fills, the filter stops taking requests,
// the middle queue fills and full rises; no request or result is lost.
// The change limit is written over cfg_valid/cfg_data, which is always ready.
// Change it only while no request is in flight; the block does not enforce this.
// Synchronous reset (rst_n low) empties both queues, clears all stored
// temperatures and first-reading flags and sets the change limit to 80.
`default_nettype none

module temp_sensor_decode_spike_filter
  import tsd_pkg::*;
(
  input  var logic               clk,
  input  var logic               rst_n,
  input  var logic               cfg_valid,
  output logic                   cfg_ready,
  input  var logic [LIMIT_W-1:0] cfg_data,
  input  var logic               push,
  output logic                   full,
  input  var in_req_t            in_req,
  output logic                   empty,
  input  var logic               pop,
  output out_rsp_t               out_rsp
);

  logic [LIMIT_W-1:0] change_limit_r;
  dec_item_t          dec_item;
  dec_item_t          mid_item;
  logic               mid_empty;
  logic               mid_take;

  // Configuration register; writes always complete at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      change_limit_r <= cfg_data;
    end
  end

  // Decode and classify the incoming request.
  tsd_decode u_decode (
    .req  (in_req),
    .item (dec_item)
  );

  // Queue between decoder and filter.
  tsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (dec_item),
    .full    (full),
    .rd_en   (mid_take),
    .rd_item (mid_item),
    .empty   (mid_empty)
  );

  // Per-sensor filter and result queue.
  tsd_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .change_limit (change_limit_r),
    .item         (mid_item),
    .item_valid   (!mid_empty),
    .item_take    (mid_take),
    .rsp          (out_rsp),
    .rsp_empty    (empty),
    .rsp_pop      (pop)
  );

endmodule

`default_nettype wire
